// File: design/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the bounded sequential list.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // fixed port widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 11;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;
  localparam int CNT_O_W = 11;

  localparam int CMP_W = (POS_W > COUNT_W) ? POS_W : COUNT_W;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_APPEND    = 3'd1,
    OP_INSERT    = 3'd2,
    OP_REM_FIRST = 3'd3,
    OP_REM_LAST  = 3'd4,
    OP_REM_AT    = 3'd5
  } sal_op_t;

  typedef struct packed {
    logic load;    // capture request fields
    logic start;   // set up shift cursor and length
    logic step;    // advance one shift step
    logic finish;  // commit count, final write, load result
  } sal_cmd_t;

  typedef struct packed {
    logic early;   // rejected or clear: no shift needed
    logic done;    // shift pass drained
  } sal_stat_t;

endpackage

// File: design/sal_ram.sv
// ----------------------------------------------------------------------------
// sal_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sal_datapath.sv
// ----------------------------------------------------------------------------
// sal_datapath
// Entry store, entry count, shift cursor and result registers. Inserts read
// downward and write one slot up; removes read upward and write one slot
// down, the first read word being the removed entry.
// ----------------------------------------------------------------------------
module sal_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sal_pkg::sal_cmd_t           cmd,
  output sal_pkg::sal_stat_t          stat,
  input  logic [sal_pkg::OP_W-1:0]    operation,
  input  logic [sal_pkg::POS_W-1:0]   position,
  input  logic [sal_pkg::IN_W-1:0]    entry_data,
  output logic [sal_pkg::OUT_W-1:0]   removed_entry,
  output logic                        error,
  output logic [sal_pkg::CNT_O_W-1:0] entry_count
);
  import sal_pkg::*;

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [COUNT_W-1:0]    cnt_dec;
  logic [COUNT_W-1:0]    left;
  logic [ADDR_W-1:0]     cur;
  logic [ADDR_W-1:0]     paddr;
  logic [ADDR_W-1:0]     ins_addr;
  logic                  pend;
  logic                  dir_up;
  logic                  first;
  logic [DATA_WIDTH-1:0] removed_q;

  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic                  reject;
  logic                  is_ins;
  logic                  is_rem;
  logic [COUNT_W-1:0]    p_eff;

  logic                  re;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  assign cnt_ext = CMP_W'(count);
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_dec = count - COUNT_W'(1);

  always_comb begin
    reject = 1'b0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    p_eff  = '0;
    case (op_q)
      OP_CLEAR: begin
        reject = 1'b0;
      end
      OP_APPEND: begin
        reject = (count == FULL_COUNT);
        is_ins = 1'b1;
        p_eff  = count;
      end
      OP_INSERT: begin
        reject = (count == FULL_COUNT) || (pos_ext > cnt_ext);
        is_ins = 1'b1;
        p_eff  = COUNT_W'(pos_q);
      end
      OP_REM_FIRST: begin
        reject = (count == '0);
        is_rem = 1'b1;
      end
      OP_REM_LAST: begin
        reject = (count == '0);
        is_rem = 1'b1;
        p_eff  = cnt_dec;
      end
      OP_REM_AT: begin
        reject = (pos_ext >= cnt_ext);
        is_rem = 1'b1;
        p_eff  = COUNT_W'(pos_q);
      end
      default: begin
        reject = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (reject) begin
      count_next = count;
    end else if (op_q == OP_CLEAR) begin
      count_next = '0;
    end else if (is_ins) begin
      count_next = count + COUNT_W'(1);
    end else if (is_rem) begin
      count_next = cnt_dec;
    end else begin
      count_next = count;
    end
  end

  assign stat.early = reject || (op_q == OP_CLEAR);
  assign stat.done  = (left == '0) && !pend;

  // store port control
  assign re = cmd.step && (left != '0);
  assign we = (cmd.step && pend && (dir_up || !first)) ||
              (cmd.finish && is_ins && !reject);
  always_comb begin
    if (cmd.finish) begin
      waddr = ins_addr;
      wdata = data_q;
    end else begin
      waddr = dir_up ? (paddr + ADDR_W'(1)) : (paddr - ADDR_W'(1));
      wdata = rdata;
    end
  end

  sal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (cur),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      left  <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.start) begin
        left <= count - p_eff;
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= re;
        if (re) begin
          left <= left - COUNT_W'(1);
        end
      end
      if (cmd.finish) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      pos_q  <= position;
      data_q <= DATA_WIDTH'(entry_data);
    end
    if (cmd.start) begin
      cur      <= is_ins ? cnt_dec[ADDR_W-1:0] : p_eff[ADDR_W-1:0];
      ins_addr <= p_eff[ADDR_W-1:0];
      dir_up   <= is_ins;
      first    <= is_rem;
    end else if (cmd.step) begin
      if (re) begin
        cur   <= dir_up ? (cur - ADDR_W'(1)) : (cur + ADDR_W'(1));
        paddr <= cur;
      end
      // first word read by a remove is the removed entry
      if (pend && !dir_up && first) begin
        removed_q <= rdata;
        first     <= 1'b0;
      end
    end
    if (cmd.finish) begin
      removed_entry <= (is_rem && !reject) ? OUT_W'(removed_q) : '0;
      error         <= reject;
      entry_count   <= CNT_O_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above depth");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != cur))
    else $error("store read and write hit the same address");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !pend)
    else $error("finish with a shift step outstanding");

endmodule

// File: design/sal_ctrl.sv
// ----------------------------------------------------------------------------
// sal_ctrl
// Controller: takes one request, checks it, runs any shift pass it needs and
// hands the result to the output register once the output side is free.
// ----------------------------------------------------------------------------
module sal_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sal_pkg::sal_cmd_t   cmd,
  input  sal_pkg::sal_stat_t  stat
);
  import sal_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.early) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
        if (stat.done && out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while held");

  a_load_to_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SETUP))
    else $error("request load not followed by setup");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid)
    else $error("finished result not presented");

endmodule

// File: design/sequential_array_list.sv
// ----------------------------------------------------------------------------
// sequential_array_list
// Clear and rejected requests skip the shift pass; append and insert at the end
// move no entries, remove last reads one, insert and remove at a position read
// (count - position) entries and remove first reads count, one entry moved per
// cycle through the store's single read port. The next request is accepted the
// cycle after the result is formed; a result still stalled at the output holds
// the next one back. Reset clears the count, shift and controller state only.
// ----------------------------------------------------------------------------
module sequential_array_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [sal_pkg::OP_W-1:0]    operation,
  input  logic [sal_pkg::POS_W-1:0]   position,
  input  logic [sal_pkg::IN_W-1:0]    entry_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [sal_pkg::OUT_W-1:0]   removed_entry,
  output logic                        error,
  output logic [sal_pkg::CNT_O_W-1:0] entry_count
);
  import sal_pkg::*;

  sal_cmd_t  cmd;
  sal_stat_t stat;

  sal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sal_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .position      (position),
    .entry_data    (entry_data),
    .removed_entry (removed_entry),
    .error         (error),
    .entry_count   (entry_count)
  );

endmodule
